>>> src/hlfp_pkg.sv
// Shared types, constants and helpers of the hex-length frame parser.
package hlfp_pkg;

  localparam int MAX_BODY = 64;
  localparam int ADDR_W   = $clog2(MAX_BODY);
  localparam int LEN_W    = $clog2(MAX_BODY + 1);

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [3:0] NIB_TEN   = 4'd10;

  localparam logic [1:0] CFG_START = 2'd0;
  localparam logic [1:0] CFG_SEP   = 2'd1;
  localparam logic [1:0] CFG_END   = 2'd2;

  localparam logic [7:0] RST_START = 8'd64;
  localparam logic [7:0] RST_SEP   = 8'd58;
  localparam logic [7:0] RST_END   = 8'd10;

  typedef enum logic [3:0] {
    PH_WAIT, PH_LEN_HI, PH_LEN_LO, PH_LEN_SEP, PH_BODY,
    PH_CHK_SEP, PH_CHK_HI, PH_CHK_LO, PH_END
  } phase_t;

  typedef enum logic [1:0] {
    ST_BUSY  = 2'd0,
    ST_READY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MD_PARSE, MD_READ, MD_SEND
  } mode_t;

  typedef struct packed {
    logic              emit;
    status_t           status;
    logic              drain;
    logic [LEN_W-1:0]  len;
  } parse_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] body_byte;
    logic [5:0] body_pos;
    logic [6:0] body_length;
    logic       last;
  } result_t;

  // bit 4 flags a valid uppercase hex digit, bits 3:0 carry its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      r = {1'b1, 4'(c - CHAR_0)};
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      r = {1'b1, 4'(c - CHAR_A) + NIB_TEN};
    end
    return r;
  endfunction

endpackage

>>> src/hlfp_if.sv
// Valid/ready channel interfaces for received bytes and parser results.
interface hlfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] body_byte;
  logic [5:0] body_pos;
  logic [6:0] body_length;
  logic       last;
  modport source (output valid, output status, output body_byte, output body_pos,
                  output body_length, output last, input ready);
  modport sink (input valid, input status, input body_byte, input body_pos,
                input body_length, input last, output ready);
endinterface

>>> src/hex_length_frame_parser_core.sv
// Top level of the hex-length frame parser.
//
//   channel  dir  transaction
//   in_ch    in   one received byte (rx_byte)
//   out_ch   out  status, body_byte, body_pos, body_length, last
//   cfg_*    in   register write: index, 8-bit data
//
// Parsing takes one byte per cycle unless a readout runs or the output stalls;
// every byte but a valid end byte gives one result. A valid end byte starts the readout:
// each body byte takes the body RAM's registered read, then the output register load.
// A stalled output holds the output register and drops in_ch.ready.
// Reset is synchronous; the body RAM is not cleared.
module hex_length_frame_parser_core
  import hlfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hlfp_in_if.sink     in_ch,
  hlfp_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] start_char_r;
  logic [7:0] sep_char_r;
  logic [7:0] end_char_r;

  logic       acc;
  logic       in_ready;
  parse_res_t res;
  ram_wr_t    wr;
  ram_rd_t    rd;
  logic [7:0] rd_data;
  result_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= RST_START;
      sep_char_r   <= RST_SEP;
      end_char_r   <= RST_END;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_START: start_char_r <= cfg_wdata;
        CFG_SEP:   sep_char_r   <= cfg_wdata;
        CFG_END:   end_char_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  hlfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .rx_byte    (in_ch.rx_byte),
    .start_char (start_char_r),
    .sep_char   (sep_char_r),
    .end_char   (end_char_r),
    .res        (res),
    .wr         (wr)
  );

  hlfp_ram #(
    .DEPTH (MAX_BODY),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.re),
    .raddr (rd.addr),
    .rdata (rd_data)
  );

  hlfp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .out_ready (out_ch.ready),
    .rd_data   (rd_data),
    .rd        (rd),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .in_ready  (in_ready)
  );

  assign out_ch.status      = out_res.status;
  assign out_ch.body_byte   = out_res.body_byte;
  assign out_ch.body_pos    = out_res.body_pos;
  assign out_ch.body_length = out_res.body_length;
  assign out_ch.last        = out_res.last;

endmodule

>>> src/hlfp_ram.sv
// Simple dual-port RAM with registered read data.
module hlfp_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/hlfp_parser.sv
// Frame parser: phase machine, length, checksum and body write.
module hlfp_parser
  import hlfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  input  logic [7:0] start_char,
  input  logic [7:0] sep_char,
  input  logic [7:0] end_char,
  output parse_res_t res,
  output ram_wr_t    wr
);

  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] decl_r, decl_nxt;
  logic [3:0]       lhn_r, lhn_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [3:0]       chn_r, chn_nxt;

  logic [4:0]       nib;
  logic [7:0]       len_full;
  logic [LEN_W-1:0] count_inc;
  logic             fail;
  logic             clr;
  logic             drain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      decl_r  <= '0;
      lhn_r   <= '0;
      count_r <= '0;
      xor_r   <= '0;
      chn_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      decl_r  <= decl_nxt;
      lhn_r   <= lhn_nxt;
      count_r <= count_nxt;
      xor_r   <= xor_nxt;
      chn_r   <= chn_nxt;
    end
  end

  assign nib       = hex_nibble(rx_byte);
  assign len_full  = {lhn_r, nib[3:0]};
  assign count_inc = count_r + LEN_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    decl_nxt  = decl_r;
    lhn_nxt   = lhn_r;
    count_nxt = count_r;
    xor_nxt   = xor_r;
    chn_nxt   = chn_r;
    fail      = 1'b0;
    clr       = 1'b0;
    drain     = 1'b0;
    wr.we     = 1'b0;
    wr.addr   = count_r[ADDR_W-1:0];
    wr.data   = rx_byte;
    if (acc && rx_byte != CHAR_CR) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rx_byte == start_char) begin
            clr = 1'b1;
          end
        end
        PH_LEN_HI: begin
          if (!nib[4]) begin
            fail = 1'b1;
          end else begin
            lhn_nxt   = nib[3:0];
            xor_nxt   = xor_r ^ rx_byte;
            phase_nxt = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          if (!nib[4] || len_full == 8'd0 || len_full > 8'(MAX_BODY)) begin
            fail = 1'b1;
          end else begin
            decl_nxt  = LEN_W'(len_full);
            xor_nxt   = xor_r ^ rx_byte;
            phase_nxt = PH_LEN_SEP;
          end
        end
        PH_LEN_SEP: begin
          if (rx_byte != sep_char) begin
            fail = 1'b1;
          end else begin
            xor_nxt   = xor_r ^ rx_byte;
            count_nxt = '0;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          wr.we     = (count_r < LEN_W'(MAX_BODY));
          xor_nxt   = xor_r ^ rx_byte;
          count_nxt = count_inc;
          if (count_inc >= decl_r) begin
            phase_nxt = PH_CHK_SEP;
          end
        end
        PH_CHK_SEP: begin
          if (rx_byte != sep_char) begin
            fail = 1'b1;
          end else begin
            phase_nxt = PH_CHK_HI;
          end
        end
        PH_CHK_HI: begin
          if (!nib[4]) begin
            fail = 1'b1;
          end else begin
            chn_nxt   = nib[3:0];
            phase_nxt = PH_CHK_LO;
          end
        end
        PH_CHK_LO: begin
          if (!nib[4]) begin
            fail = 1'b1;
          end else begin
            xor_nxt   = xor_r ^ {chn_r, nib[3:0]};
            phase_nxt = PH_END;
          end
        end
        PH_END: begin
          if (rx_byte != end_char || xor_r != 8'd0 || decl_r == '0 ||
              decl_r > LEN_W'(MAX_BODY)) begin
            fail = 1'b1;
          end else begin
            drain = 1'b1;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
      if (fail || clr || drain) begin
        phase_nxt = PH_WAIT;
        decl_nxt  = '0;
        lhn_nxt   = '0;
        count_nxt = '0;
        xor_nxt   = '0;
        chn_nxt   = '0;
      end
      if (clr || (fail && rx_byte == start_char)) begin
        phase_nxt = PH_LEN_HI;
      end
    end
  end

  assign res.emit   = acc && !drain;
  assign res.status = fail ? ST_ERROR : ST_BUSY;
  assign res.drain  = drain;
  assign res.len    = decl_r;

endmodule

>>> src/hlfp_seq.sv
// Output register and body readout sequencer.
module hlfp_seq
  import hlfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  parse_res_t res,
  input  logic       out_ready,
  input  logic [7:0] rd_data,
  output ram_rd_t    rd,
  output logic       out_valid,
  output result_t    out_res,
  output logic       in_ready
);

  mode_t             mode_r, mode_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              valid_r, valid_nxt;
  result_t           res_r, res_nxt;
  logic              free;
  logic              is_last;

  assign free    = !valid_r || out_ready;
  assign is_last = (LEN_W'(k_r) + LEN_W'(1)) == len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MD_PARSE;
      valid_r <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    len_r <= len_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    mode_nxt  = mode_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    res_nxt   = res_r;
    valid_nxt = valid_r && !out_ready;
    rd.re     = 1'b0;
    rd.addr   = k_r;
    unique case (mode_r)
      MD_PARSE: begin
        if (res.emit) begin
          valid_nxt           = 1'b1;
          res_nxt.status      = res.status;
          res_nxt.body_byte   = '0;
          res_nxt.body_pos    = '0;
          res_nxt.body_length = '0;
          res_nxt.last        = 1'b1;
        end
        if (res.drain) begin
          k_nxt    = '0;
          len_nxt  = res.len;
          mode_nxt = MD_READ;
        end
      end
      MD_READ: begin
        rd.re    = 1'b1;
        mode_nxt = MD_SEND;
      end
      MD_SEND: begin
        if (free) begin
          valid_nxt           = 1'b1;
          res_nxt.status      = ST_READY;
          res_nxt.body_byte   = rd_data;
          res_nxt.body_pos    = 6'(k_r);
          res_nxt.body_length = 7'(len_r);
          res_nxt.last        = is_last;
          if (is_last) begin
            mode_nxt = MD_PARSE;
          end else begin
            k_nxt    = k_r + ADDR_W'(1);
            mode_nxt = MD_READ;
          end
        end
      end
      default: begin
        mode_nxt = MD_PARSE;
      end
    endcase
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign in_ready  = (mode_r == MD_PARSE) && free;

endmodule

>>> src/hlfp_checker.sv
// Port-level assertions of the frame parser, bound to the top level.
module hlfp_checker
  import hlfp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [7:0] body_byte,
  input logic [5:0] body_pos,
  input logic [6:0] body_length,
  input logic       last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(body_byte)
      && $stable(body_pos) && $stable(last))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_BUSY || status == ST_READY || status == ST_ERROR)
    else $error("undefined status code");

  a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_READY |->
      body_byte == 8'd0 && body_pos == 6'd0 && body_length == 7'd0 && last)
    else $error("non-body result carries body fields");

  a_readout_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_READY && !last |-> !in_ready)
    else $error("input taken during body readout");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_READY |->
      body_length != 7'd0 && {1'b0, body_pos} < body_length
      && (last == ({1'b0, body_pos} + 7'd1 == body_length)))
    else $error("body position inconsistent with length");

endmodule

bind hex_length_frame_parser_core hlfp_checker u_hlfp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .body_byte   (out_ch.body_byte),
  .body_pos    (out_ch.body_pos),
  .body_length (out_ch.body_length),
  .last        (out_ch.last)
);

>>> sim/hex_length_frame_parser_core_test.sv
// Testbench for the hex-length frame parser: random framed byte streams checked against a frame model.
`timescale 1ns / 1ps

import hlfp_pkg::*;

class frame_checker;
  logic [7:0] start_b, sep_b, end_b;
  phase_t     ph;
  logic [6:0] want_len, body_cnt;
  logic [3:0] len_hi, chk_hi;
  logic [7:0] xor_acc;
  logic [7:0] body_mem [MAX_BODY];
  result_t    results_due[$];
  int         mismatches, checked, frames_done, faults;

  function new();
    start_b = RST_START;
    sep_b = RST_SEP;
    end_b = RST_END;
    foreach (body_mem[i]) body_mem[i] = 8'h00;
    mismatches = 0;
    checked = 0;
    frames_done = 0;
    faults = 0;
    clear_frame();
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] val);
    case (idx)
      CFG_START: start_b = val;
      CFG_SEP:   sep_b = val;
      CFG_END:   end_b = val;
      default: ;
    endcase
  endfunction

  function void clear_frame();
    ph = PH_WAIT;
    want_len = '0;
    len_hi = '0;
    body_cnt = '0;
    xor_acc = '0;
    chk_hi = '0;
  endfunction

  function int nib(logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
    if (c >= CHAR_A && c <= CHAR_F) return int'(c - CHAR_A) + 10;
    return -1;
  endfunction

  function void push_one(status_t st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    results_due.push_back(r);
  endfunction

  function void fault(logic [7:0] b);
    clear_frame();
    if (b == start_b) ph = PH_LEN_HI;
    faults++;
    push_one(ST_ERROR);
  endfunction

  function void note_byte(logic [7:0] b);
    int         n;
    logic [7:0] full_len;
    result_t    r;
    if (b == CHAR_CR) begin
      push_one(ST_BUSY);
      return;
    end
    n = nib(b);
    case (ph)
      PH_WAIT: begin
        if (b == start_b) begin
          clear_frame();
          ph = PH_LEN_HI;
        end
        push_one(ST_BUSY);
      end
      PH_LEN_HI: begin
        if (n < 0) begin
          fault(b);
        end else begin
          len_hi = 4'(n);
          xor_acc ^= b;
          ph = PH_LEN_LO;
          push_one(ST_BUSY);
        end
      end
      PH_LEN_LO: begin
        full_len = {len_hi, 4'(n)};
        if (n < 0 || full_len == 8'd0 || full_len > MAX_BODY) begin
          fault(b);
        end else begin
          want_len = full_len[6:0];
          xor_acc ^= b;
          ph = PH_LEN_SEP;
          push_one(ST_BUSY);
        end
      end
      PH_LEN_SEP: begin
        if (b != sep_b) begin
          fault(b);
        end else begin
          xor_acc ^= b;
          body_cnt = '0;
          ph = PH_BODY;
          push_one(ST_BUSY);
        end
      end
      PH_BODY: begin
        if (body_cnt < MAX_BODY) body_mem[body_cnt[5:0]] = b;
        xor_acc ^= b;
        body_cnt++;
        if (body_cnt >= want_len) ph = PH_CHK_SEP;
        push_one(ST_BUSY);
      end
      PH_CHK_SEP: begin
        if (b != sep_b) begin
          fault(b);
        end else begin
          ph = PH_CHK_HI;
          push_one(ST_BUSY);
        end
      end
      PH_CHK_HI: begin
        if (n < 0) begin
          fault(b);
        end else begin
          chk_hi = 4'(n);
          ph = PH_CHK_LO;
          push_one(ST_BUSY);
        end
      end
      PH_CHK_LO: begin
        if (n < 0) begin
          fault(b);
        end else begin
          xor_acc ^= {chk_hi, 4'(n)};
          ph = PH_END;
          push_one(ST_BUSY);
        end
      end
      PH_END: begin
        if (b != end_b || xor_acc != 8'd0 || want_len == 7'd0 || want_len > MAX_BODY) begin
          fault(b);
        end else begin
          for (int k = 0; k < int'(want_len); k++) begin
            r.status = ST_READY;
            r.body_byte = body_mem[k];
            r.body_pos = 6'(k);
            r.body_length = want_len;
            r.last = (k == int'(want_len) - 1);
            results_due.push_back(r);
          end
          frames_done++;
          clear_frame();
        end
      end
      default: fault(b);
    endcase
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task check(result_t got);
    result_t want;
    if (results_due.size() == 0) begin
      report($sformatf("unexpected result st=%0d byte=%h pos=%0d len=%0d last=%b",
                       got.status, got.body_byte, got.body_pos, got.body_length, got.last));
      return;
    end
    want = results_due.pop_front();
    checked++;
    if (got.status !== want.status || got.body_byte !== want.body_byte ||
        got.body_pos !== want.body_pos || got.body_length !== want.body_length ||
        got.last !== want.last) begin
      report($sformatf("got st=%0d byte=%h pos=%0d len=%0d last=%b, want st=%0d byte=%h pos=%0d len=%0d last=%b",
                       got.status, got.body_byte, got.body_pos, got.body_length, got.last,
                       want.status, want.body_byte, want.body_pos, want.body_length, want.last));
    end
  endtask
endclass

module hex_length_frame_parser_core_test;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    FLT_NONE, FLT_LEN_DIGIT, FLT_LEN_RANGE, FLT_SEP_LEN, FLT_SEP_BODY,
    FLT_CHK_DIGIT, FLT_CHECK, FLT_END, FLT_RESTART
  } frame_fault_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  hlfp_in_if  in_ch ();
  hlfp_out_if out_ch ();

  hex_length_frame_parser_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  frame_checker frame_model;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_req = 1'b0;
  int           bytes_sent = 0;
  int           frames_sent = 0;
  int           settings_run = 1;
  int           quiet_cycles = 0;

  always #5 clk = ~clk;

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.body_byte = out_ch.body_byte;
      got.body_pos = out_ch.body_pos;
      got.body_length = out_ch.body_length;
      got.last = out_ch.last;
      frame_model.check(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < NIB_TEN) ? CHAR_0 + 8'(n) : CHAR_A + 8'(n - NIB_TEN);
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom); while (b == x || b == CHAR_CR);
    return b;
  endfunction

  function automatic logic [7:0] bad_digit();
    case ($urandom_range(3))
      0: return 8'h61 + 8'($urandom_range(5));
      1: return CHAR_F + 8'($urandom_range(20, 1));
      2: return $urandom_range(1) ? CHAR_0 - 8'd1 : CHAR_9 + 8'd1;
      default: return other_than(CHAR_CR);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    frame_model.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int unsigned len, input frame_fault_t flt);
    logic [7:0] fr[$];
    logic [7:0] sum, b, len_field, chk, d_hi, d_lo;
    int         fill, cut;
    len_field = 8'(len);
    if (flt == FLT_LEN_RANGE)
      len_field = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, MAX_BODY + 1));
    d_hi = hex_char(len_field[7:4]);
    d_lo = hex_char(len_field[3:0]);
    if (flt == FLT_LEN_DIGIT) begin
      if ($urandom_range(1)) d_hi = bad_digit();
      else d_lo = bad_digit();
    end
    fr.push_back(frame_model.start_b);
    fr.push_back(d_hi);
    fr.push_back(d_lo);
    sum = d_hi ^ d_lo;
    b = (flt == FLT_SEP_LEN) ? other_than(frame_model.sep_b) : frame_model.sep_b;
    fr.push_back(b);
    sum ^= b;
    fill = $urandom_range(7);
    for (int i = 0; i < int'(len); i++) begin
      b = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
      if (b == CHAR_CR) b = 8'h8D;
      fr.push_back(b);
      sum ^= b;
    end
    fr.push_back((flt == FLT_SEP_BODY) ? other_than(frame_model.sep_b) : frame_model.sep_b);
    chk = sum ^ ((flt == FLT_CHECK) ? 8'($urandom_range(255, 1)) : 8'd0);
    d_hi = hex_char(chk[7:4]);
    d_lo = hex_char(chk[3:0]);
    if (flt == FLT_CHK_DIGIT) begin
      if ($urandom_range(1)) d_hi = bad_digit();
      else d_lo = bad_digit();
    end
    fr.push_back(d_hi);
    fr.push_back(d_lo);
    fr.push_back((flt == FLT_END) ? other_than(frame_model.end_b) : frame_model.end_b);
    cut = (flt == FLT_RESTART) ? $urandom_range(fr.size() - 1, 1) : -1;
    foreach (fr[i]) begin
      if (i == cut) send_byte(frame_model.start_b);
      if (i > 0 && $urandom_range(11) == 0) send_byte(CHAR_CR);
      send_byte(fr[i]);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (frame_model.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] s, input logic [7:0] p, input logic [7:0] e);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_START;
    cfg_wdata <= s;
    @(posedge clk);
    frame_model.set_reg(CFG_START, s);
    cfg_idx <= CFG_SEP;
    cfg_wdata <= p;
    @(posedge clk);
    frame_model.set_reg(CFG_SEP, p);
    cfg_idx <= CFG_END;
    cfg_wdata <= e;
    @(posedge clk);
    frame_model.set_reg(CFG_END, e);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  task automatic run_phase(input int budget);
    int first, r, len;
    frame_fault_t flt;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      case (frames_sent % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      r = $urandom_range(99);
      len = (r < 80) ? $urandom_range(6, 1) : (r < 96) ? $urandom_range(20, 7)
                                                      : $urandom_range(MAX_BODY, 21);
      flt = ($urandom_range(99) < 50) ? FLT_NONE : frame_fault_t'($urandom_range(8, 1));
      send_frame(len, flt);
      frames_sent++;
    end
    drain();
  endtask

  initial begin
    frame_model = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_START;
    cfg_wdata <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(RST_START);
    send_byte("0");
    send_byte("1");
    send_byte(CHAR_CR);
    send_byte(RST_SEP);
    send_byte(8'h00);
    send_byte(RST_SEP);
    send_byte("3");
    send_byte("B");
    send_byte(RST_END);
    send_byte(RST_START);
    send_byte("0");
    send_byte("a");
    send_byte(RST_START);
    send_byte("4");
    send_byte("1");
    send_byte(RST_START);
    send_byte("0");
    send_byte("0");
    send_byte(RST_START);
    send_byte(RST_START);
    send_byte("G");
    drain();

    hold_req = 1'b1;
    send_frame(MAX_BODY, FLT_NONE);
    run_phase(15);
    apply_setting(8'h00, 8'hFF, 8'h00);
    run_phase(50);
    apply_setting(8'hFF, 8'h00, 8'hFF);
    run_phase(50);
    apply_setting("A", "0", "F");
    run_phase(50);
    apply_setting(RST_START, RST_SEP, RST_END);
    run_phase(50);

    $display("Sent %0d bytes under %0d register settings; %0d frames delivered, %0d faults",
             bytes_sent, settings_run, frame_model.frames_done, frame_model.faults);
    $display("Checked %0d results, %0d mismatches", frame_model.checked,
             frame_model.mismatches);
    if (frame_model.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/hlfp_pkg.sv
src/hlfp_if.sv
src/hlfp_ram.sv
src/hlfp_parser.sv
src/hlfp_seq.sv
src/hex_length_frame_parser_core.sv
src/hlfp_checker.sv
sim/hex_length_frame_parser_core_test.sv
